@@ sv/anm_pkg.sv @@
// Shared types and constants for the alias / node-id map table.
package anm_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ALIAS_W = 12;
  localparam int NODE_W  = 48;
  localparam int SLOT_W  = 4;
  localparam int ACT_W   = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR      = 3'd0,
    ACT_REGISTER   = 3'd1,
    ACT_UNREGISTER = 3'd2,
    ACT_FIND_ALIAS = 3'd3,
    ACT_FIND_NODE  = 3'd4
  } action_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture input word, rewind scan index
    logic step;    // advance scan index
    logic finish;  // commit table update and load result register
  } anm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;  // current slot ends the scan (match, last slot or no scan)
    logic out_free;  // result register can take a word this cycle
  } anm_sts_t;

endpackage

@@ sv/alias_node_id_map_table_top.sv @@
// Top level of the alias / node-id map table: controller plus datapath.
//
//  channel  dir  handshake                    tdata (low bit up)             tuser
//  s_axis   in   s_axis_tvalid/s_axis_tready  alias_key[11:0], node_key[59:12] action[2:0]
//  m_axis   out  m_axis_tvalid/m_axis_tready  slot[3:0], alias_out[15:4],      hit[0]
//                                             node_out[63:16]
//
// Flow: one word at a time; the scan reads one slot per cycle and stops at the first
// match or at the last slot, then the result is registered (clear and unused: no scan).
// The next word is taken only once the previous result has been loaded.
// Reset: rst_ni clears all valid bits (every slot free) and the result valid flag.
// Stalls: a finished scan holds its final slot until the result register is free;
// the input side can be accepted while the previous result word still waits.
module alias_node_id_map_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // alias_key[11:0], node_key[59:12], zero fill
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // slot[3:0], alias_out[15:4], node_out[63:16]
  output logic [0:0]  m_axis_tuser    // hit[0]
);
  import anm_pkg::*;

  anm_cmd_t cmd;
  anm_sts_t sts;

  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot;
  logic [ALIAS_W-1:0]  out_alias;
  logic [NODE_W-1:0]   out_node;

  anm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  anm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_action_i (s_axis_tuser),
    .in_alias_i  (s_axis_tdata[11:0]),
    .in_node_i   (s_axis_tdata[59:12]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (out_hit),
    .out_slot_o  (out_slot),
    .out_alias_o (out_alias),
    .out_node_o  (out_node)
  );

  // fields packed from bit 0 upward; 64 bits exactly, no fill needed
  assign m_axis_tdata = {out_node, out_alias, out_slot};
  assign m_axis_tuser = out_hit;

endmodule

@@ sv/anm_ctrl.sv @@
// Controller state machine for the alias / node-id map table.
module anm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  anm_pkg::anm_sts_t sts_i,
  output anm_pkg::anm_cmd_t cmd_o
);
  import anm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_end && sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.step    = (state_q == ST_SCAN) && !sts_i.scan_end;
  assign cmd_o.finish  = (state_q == ST_SCAN) && sts_i.scan_end && sts_i.out_free;

endmodule

@@ sv/anm_dpath.sv @@
// Datapath: slot table, scan counter, compare and result register.
module anm_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  anm_pkg::anm_cmd_t            cmd_i,
  output anm_pkg::anm_sts_t            sts_o,
  input  logic [anm_pkg::ACT_W-1:0]    in_action_i,
  input  logic [anm_pkg::ALIAS_W-1:0]  in_alias_i,
  input  logic [anm_pkg::NODE_W-1:0]   in_node_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_hit_o,
  output logic [anm_pkg::SLOT_W-1:0]   out_slot_o,
  output logic [anm_pkg::ALIAS_W-1:0]  out_alias_o,
  output logic [anm_pkg::NODE_W-1:0]   out_node_o
);
  import anm_pkg::*;

  // captured request
  action_e             act_q;
  logic [ALIAS_W-1:0]  akey_q;
  logic [NODE_W-1:0]   nkey_q;
  logic [IDX_W-1:0]    idx_q;

  // slot table; an entry without its valid bit reads as zero
  logic [ALIAS_W-1:0]  alias_mem_q [SLOTS];
  logic [NODE_W-1:0]   node_mem_q  [SLOTS];
  logic [SLOTS-1:0]    valid_q;

  // result register
  logic                out_valid_q;
  logic                out_hit_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [ALIAS_W-1:0]  out_alias_q;
  logic [NODE_W-1:0]   out_node_q;

  logic [ALIAS_W-1:0]  ent_alias;
  logic [NODE_W-1:0]   ent_node;
  logic                match;
  logic                no_scan;
  logic                last;
  logic [IDX_W+SLOT_W-1:0] idx_ext;
  logic                res_hit;
  logic [SLOT_W-1:0]   res_slot;
  logic [ALIAS_W-1:0]  res_alias;
  logic [NODE_W-1:0]   res_node;

  assign ent_alias = valid_q[idx_q] ? alias_mem_q[idx_q] : '0;
  assign ent_node  = valid_q[idx_q] ? node_mem_q[idx_q]  : '0;
  assign last      = (idx_q == IDX_W'(SLOTS - 1));
  assign idx_ext   = {{SLOT_W{1'b0}}, idx_q};

  always_comb begin
    match   = 1'b0;
    no_scan = 1'b0;
    case (act_q)
      ACT_CLEAR:      no_scan = 1'b1;
      ACT_REGISTER:   match   = (ent_alias == '0);
      ACT_UNREGISTER: match   = (ent_alias == akey_q);
      ACT_FIND_ALIAS: match   = (ent_alias == akey_q);
      ACT_FIND_NODE:  match   = (ent_node == nkey_q);
      default:        no_scan = 1'b1;
    endcase
  end

  always_comb begin
    res_hit   = 1'b0;
    res_slot  = '0;
    res_alias = '0;
    res_node  = '0;
    if (act_q == ACT_CLEAR) begin
      res_hit = 1'b1;
    end else if (match) begin
      res_hit  = 1'b1;
      res_slot = idx_ext[SLOT_W-1:0];
      if (act_q == ACT_REGISTER) begin
        res_alias = akey_q;
        res_node  = nkey_q;
      end else begin
        res_alias = ent_alias;
        res_node  = ent_node;
      end
    end
  end

  assign sts_o.scan_end = no_scan || match || last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // request capture and scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(in_action_i);
      akey_q <= in_alias_i;
      nkey_q <= in_node_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // table contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && match && (act_q == ACT_REGISTER)) begin
      alias_mem_q[idx_q] <= akey_q;
      node_mem_q[idx_q]  <= nkey_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.finish) begin
      if (act_q == ACT_CLEAR) begin
        valid_q <= '0;
      end else if (match && (act_q == ACT_REGISTER)) begin
        valid_q[idx_q] <= 1'b1;
      end else if (match && (act_q == ACT_UNREGISTER)) begin
        valid_q[idx_q] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_hit_q   <= res_hit;
      out_slot_q  <= res_slot;
      out_alias_q <= res_alias;
      out_node_q  <= res_node;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_slot_o  = out_slot_q;
  assign out_alias_o = out_alias_q;
  assign out_node_o  = out_node_q;

  // a result never overwrites one still waiting downstream
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");

  // the scan never runs past the last slot
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !last)
    else $error("scan index stepped past last slot");

  // clear leaves every slot free
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (act_q == ACT_CLEAR)) |=> (valid_q == '0))
    else $error("table not empty after clear");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q) |->
      ((out_slot_q == '0) && (out_alias_q == '0) && (out_node_q == '0)))
    else $error("miss result with nonzero fields");

endmodule
